[sv/skt_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and codes of the sorted key table.
package skt_pkg;

  localparam int CAPACITY    = 32;
  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_W       = 32;
  localparam int PAYLOAD_W   = 16;
  localparam int RANK_W      = 5;
  localparam int ENT_CNT_W   = 6;
  localparam int ENTRY_W     = KEY_W + PAYLOAD_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAYLOAD_W-1:0]    pl;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_WRNEW = 4'b1000
  } state_t;

endpackage

[sv/sorted_key_table_core.sv]
`timescale 1ns / 1ps
// Top level of the sorted key table: request sequencer around one entry RAM.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -------------------------------
//  request   in_operation, in_key, in_payload        taken when start && !busy
//  result    out_status, out_rank,                    out_valid, one cycle, no stall
//            out_found_payload, out_entry_count
//
// Sequence: a find, a miss, a duplicate, a full table or the unused code ends
// with the scan; a remove adds the shift, an insert the shift and the write of
// the new entry. With n the entry count, the scan stops at the rank and the
// shift moves the entries above it (n - rank on an insert, n - rank - 1 on a
// remove). The result shows in the same cycle as busy falls. The single RAM
// read/write port pair sets the pace: the scan reads
// one entry a cycle, the shift moves one entry a cycle. Reset (rst_n low at a
// clock edge) clears the control state and the entry count; the RAM holds no
// reset value and needs no clearing pass, since only entries below the count
// are read. The result register parts the two sides, so a new request is
// taken while a result is shown.
module sorted_key_table_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_operation,
  input  logic signed [skt_pkg::KEY_W-1:0]      in_key,
  input  logic [skt_pkg::PAYLOAD_W-1:0]         in_payload,
  output logic                                  out_valid,
  output logic [1:0]                            out_status,
  output logic [skt_pkg::RANK_W-1:0]            out_rank,
  output logic [skt_pkg::PAYLOAD_W-1:0]         out_found_payload,
  output logic [skt_pkg::ENT_CNT_W-1:0]         out_entry_count
);

  import skt_pkg::*;

  // Sequencer state
  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [PAYLOAD_W-1:0]    pl_r, pl_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;      // next RAM read index
  logic                    cmp_valid_r, cmp_valid_nxt; // read data in flight
  logic [CNT_W-1:0]        pos_r, pos_nxt;      // sorted position of the key
  logic [PAYLOAD_W-1:0]    hpl_r, hpl_nxt;      // payload of the removed entry
  logic [CNT_W-1:0]        rem_r, rem_nxt;      // reads left in the shift
  logic                    wb_valid_r, wb_valid_nxt;
  logic [ADDR_W-1:0]       wb_addr_r, wb_addr_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;

  // Result register
  logic                    out_valid_r;
  status_t                 out_status_r, out_status_nxt;
  logic [RANK_W-1:0]       out_rank_r, out_rank_nxt;
  logic [PAYLOAD_W-1:0]    out_pl_r, out_pl_nxt;
  logic [ENT_CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  // Result of this cycle
  logic                    res_fire;
  status_t                 res_status;
  logic [CNT_W-1:0]        res_rank;
  logic [PAYLOAD_W-1:0]    res_pl;

  // Scan decode
  logic                    scan_done;
  logic                    scan_hit;
  logic [CNT_W-1:0]        scan_pos;
  logic                    key_less;
  logic                    shift_up;

  // RAM port
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  entry_t                  ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;
  entry_t                  rd_entry;

  skt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign key_less = rd_entry.key < key_r;
  assign shift_up = (op_r == OP_INSERT);
  assign busy     = !state_r[0];

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    pl_nxt        = pl_r;
    idx_nxt       = idx_r;
    cmp_valid_nxt = cmp_valid_r;
    pos_nxt       = pos_r;
    hpl_nxt       = hpl_r;
    rem_nxt       = rem_r;
    wb_valid_nxt  = wb_valid_r;
    wb_addr_nxt   = wb_addr_r;
    count_nxt     = count_r;

    res_fire   = 1'b0;
    res_status = ST_MISSING;
    res_rank   = '0;
    res_pl     = '0;

    scan_done = 1'b0;
    scan_hit  = 1'b0;
    scan_pos  = idx_r;

    ram_we    = 1'b0;
    ram_waddr = wb_addr_r;
    ram_wdata = rd_entry;
    ram_raddr = idx_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt        = op_t'(in_operation);
          key_nxt       = in_key;
          pl_nxt        = in_payload;
          idx_nxt       = '0;
          cmp_valid_nxt = 1'b0;
          state_nxt     = S_SCAN;
        end
      end

      S_SCAN: begin
        // First entry not below the key ends the scan; so does the end of the table.
        if (cmp_valid_r && !key_less) begin
          scan_done = 1'b1;
          scan_pos  = idx_r - CNT_W'(1);
          scan_hit  = (rd_entry.key == key_r);
        end else if (idx_r == count_r) begin
          scan_done = 1'b1;
          scan_pos  = idx_r;
        end else begin
          idx_nxt       = idx_r + CNT_W'(1);
          cmp_valid_nxt = 1'b1;
        end

        if (scan_done) begin
          cmp_valid_nxt = 1'b0;
          pos_nxt       = scan_pos;
          wb_valid_nxt  = 1'b0;
          case (op_r)
            OP_INSERT: begin
              if (scan_hit) begin
                res_fire   = 1'b1;
                res_status = ST_DUP;
                res_rank   = scan_pos;
                state_nxt  = S_IDLE;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                res_fire   = 1'b1;
                res_status = ST_FULL;
                state_nxt  = S_IDLE;
              end else begin
                // open a gap: move entries pos..count-1 up by one, top first
                rem_nxt   = count_r - scan_pos;
                idx_nxt   = count_r - CNT_W'(1);
                state_nxt = S_SHIFT;
              end
            end
            OP_FIND: begin
              res_fire = 1'b1;
              if (scan_hit) begin
                res_status = ST_DONE;
                res_rank   = scan_pos;
                res_pl     = rd_entry.pl;
              end
              state_nxt = S_IDLE;
            end
            OP_REMOVE: begin
              if (scan_hit) begin
                // close the gap: move entries pos+1..count-1 down by one
                hpl_nxt   = rd_entry.pl;
                rem_nxt   = count_r - CNT_W'(1) - scan_pos;
                idx_nxt   = scan_pos + CNT_W'(1);
                state_nxt = S_SHIFT;
              end else begin
                res_fire  = 1'b1;
                state_nxt = S_IDLE;
              end
            end
            default: begin
              res_fire  = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read one entry a cycle, write it back one place over the next cycle
        if (wb_valid_r) begin
          ram_we = 1'b1;
        end
        if (rem_r != '0) begin
          rem_nxt      = rem_r - CNT_W'(1);
          wb_valid_nxt = 1'b1;
          if (shift_up) begin
            idx_nxt     = idx_r - CNT_W'(1);
            wb_addr_nxt = ADDR_W'(idx_r + CNT_W'(1));
          end else begin
            idx_nxt     = idx_r + CNT_W'(1);
            wb_addr_nxt = ADDR_W'(idx_r - CNT_W'(1));
          end
        end else begin
          wb_valid_nxt = 1'b0;
          if (shift_up) begin
            state_nxt = S_WRNEW;
          end else begin
            count_nxt  = count_r - CNT_W'(1);
            res_fire   = 1'b1;
            res_status = ST_DONE;
            res_rank   = pos_r;
            res_pl     = hpl_r;
            state_nxt  = S_IDLE;
          end
        end
      end

      S_WRNEW: begin
        ram_we        = 1'b1;
        ram_waddr     = pos_r[ADDR_W-1:0];
        ram_wdata.key = key_r;
        ram_wdata.pl  = pl_r;
        count_nxt     = count_r + CNT_W'(1);
        res_fire      = 1'b1;
        res_status    = ST_DONE;
        res_rank      = pos_r;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_status_nxt = out_status_r;
    out_rank_nxt   = out_rank_r;
    out_pl_nxt     = out_pl_r;
    out_cnt_nxt    = out_cnt_r;
    if (res_fire) begin
      out_status_nxt = res_status;
      out_rank_nxt   = RANK_W'(res_rank);
      out_pl_nxt     = res_pl;
      out_cnt_nxt    = ENT_CNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_valid_r <= 1'b0;
      wb_valid_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      wb_valid_r  <= wb_valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    pl_r         <= pl_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    hpl_r        <= hpl_nxt;
    rem_r        <= rem_nxt;
    wb_addr_r    <= wb_addr_nxt;
    out_status_r <= out_status_nxt;
    out_rank_r   <= out_rank_nxt;
    out_pl_r     <= out_pl_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_rank          = out_rank_r;
  assign out_found_payload = out_pl_r;
  assign out_entry_count   = out_cnt_r;

endmodule

[sv/skt_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
